// ===== rtl/rfe_pkg.sv =====
// ----------------------------------------------------------------------------
// rfe_pkg
// Shared constants, types and the CRC-16 byte step for the report frame
// encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rfe_pkg;

  // frame limits
  localparam int unsigned MAX_FRAME_BYTES = 32;
  localparam int unsigned HDR_BYTES       = 7;
  localparam int unsigned CRC_BYTES       = 2;
  localparam int unsigned MAX_PAYLOAD     = MAX_FRAME_BYTES - HDR_BYTES - CRC_BYTES;
  localparam int unsigned LEN_W           = $clog2(MAX_PAYLOAD + 1);

  // header and type constants
  localparam logic [7:0] FRAME_MAGIC   = 8'hA5;
  localparam logic [7:0] FRAME_VERSION = 8'h02;
  localparam logic [7:0] TYPE_MAX      = 8'd3;
  localparam logic [7:0] PAYLOAD_LIMIT = 8'(MAX_PAYLOAD);
  localparam int unsigned NUM_TYPES    = 4;
  localparam int unsigned TYPE_W       = $clog2(NUM_TYPES);

  // crc-16, unreflected, no final xor
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // command from the sequencer to the crc register
  typedef struct packed {
    logic       init;
    logic       update;
    logic [7:0] data;
  } crc_cmd_t;

  // one byte through the crc, msb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data_in);
    logic [15:0] c;
    c = crc_in ^ {data_in, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rfe_crc16.sv =====
// ----------------------------------------------------------------------------
// rfe_crc16
// Running CRC-16 register, restarted at frame start and advanced by one
// byte per command.
// ----------------------------------------------------------------------------
`default_nettype none

module rfe_crc16
  import rfe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire crc_cmd_t    cmd_i,
  output logic [15:0]      crc_o
);

  logic [15:0] crc_q;
  logic [15:0] crc_d;

  // next crc value
  always_comb begin
    crc_d = crc_q;
    if (cmd_i.init) begin
      crc_d = CRC_INIT;
    end else if (cmd_i.update) begin
      crc_d = crc16_byte(crc_q, cmd_i.data);
    end
  end

  // crc register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

`default_nettype wire

// ===== rtl/report_frame_encoder_crc16_top.sv =====
// ----------------------------------------------------------------------------
// report_frame_encoder_crc16_top
// Frames report payload bytes: header with per-type sequence number, payload,
// and a trailing CRC-16 (poly 0x1021, init 0xFFFF) over all bytes but magic.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata                               tlast      tuser
//  s_axis   in   [7:0] report_len, [15:8] payload    -          [7:0] report_type
//  m_axis   out  [7:0] out_byte                      frame_end  [0] reject
//
//  An item is held in an input register and emits one output byte per cycle,
//  unless m_axis stalls, into an output register; the held item is released with
//  its last byte and the next item is taken in that same cycle.
//  Bytes per item: 1 inside a frame, 8 for a frame start (7 header bytes plus
//  the payload byte), 2 more on the last item for the CRC, 9 for an empty
//  frame, 1 for a rejected start.
//  Reset clears the sequence counters, frame state and valid flags at once.
//  A stall on m_axis holds the output register and the item in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module report_frame_encoder_crc16_top
  import rfe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [7:0] report_len, [15:8] payload_byte
  input  wire logic [7:0]  s_axis_tuser,   // [7:0] report_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output logic             m_axis_tlast,   // frame_end
  output logic [0:0]       m_axis_tuser    // [0] reject
);

  // sequencer phases
  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_HDR    = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_CRC_LO = 3'd3;
  localparam logic [2:0] PH_CRC_HI = 3'd4;

  // header byte positions after the magic
  localparam logic [2:0] HDR_VER  = 3'd1;
  localparam logic [2:0] HDR_TYPE = 3'd2;
  localparam logic [2:0] HDR_SEQ  = 3'd4;
  localparam logic [2:0] HDR_LEN  = 3'd5;
  localparam logic [2:0] HDR_LAST = 3'd6;

  // held item
  logic             item_valid_q, item_valid_d;
  logic [7:0]       type_q, len_q, data_q;
  logic [2:0]       phase_q, phase_d;
  logic [2:0]       hdr_idx_q, hdr_idx_d;

  // frame state
  logic             in_frame_q, in_frame_d;
  logic [LEN_W-1:0] latched_len_q, latched_len_d;
  logic [LEN_W-1:0] seen_q, seen_d;
  logic [7:0]       seq_q [NUM_TYPES];
  logic             seq_inc;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_end_q, out_end_d;
  logic             out_rej_q, out_rej_d;

  logic             fire, load, last;
  logic [2:0]       phase_next;
  logic [2:0]       hdr_idx_next;
  logic             bad_start;
  logic [LEN_W:0]   seen_inc;
  logic             trailer;
  logic [15:0]      crc;
  crc_cmd_t         crc_cmd;
  logic [TYPE_W-1:0] type_sel;

  assign fire      = item_valid_q && (!out_valid_q || m_axis_tready);
  assign bad_start = (type_q > TYPE_MAX) || (len_q > PAYLOAD_LIMIT);
  assign type_sel  = type_q[TYPE_W-1:0];
  assign seen_inc  = {1'b0, seen_q} + {{LEN_W{1'b0}}, 1'b1};
  assign trailer   = seen_inc >= {1'b0, latched_len_q};

  // byte selection and sequencing for the held item
  always_comb begin
    out_byte_d     = 8'h00;
    out_end_d      = 1'b0;
    out_rej_d      = 1'b0;
    last           = 1'b0;
    phase_next     = phase_q;
    hdr_idx_next   = hdr_idx_q;
    crc_cmd.init   = 1'b0;
    crc_cmd.update = 1'b0;
    crc_cmd.data   = 8'h00;
    seq_inc        = 1'b0;
    latched_len_d  = latched_len_q;
    seen_d         = seen_q;
    in_frame_d     = in_frame_q;
    case (phase_q)
      PH_START: begin
        if (bad_start) begin
          out_rej_d = 1'b1;
          last      = 1'b1;
        end else begin
          out_byte_d    = FRAME_MAGIC;
          crc_cmd.init  = 1'b1;
          latched_len_d = len_q[LEN_W-1:0];
          seen_d        = '0;
          phase_next    = PH_HDR;
          hdr_idx_next  = HDR_VER;
        end
      end
      PH_HDR: begin
        case (hdr_idx_q)
          HDR_VER:  out_byte_d = FRAME_VERSION;
          HDR_TYPE: out_byte_d = type_q;
          HDR_SEQ:  out_byte_d = seq_q[type_sel];
          HDR_LEN:  out_byte_d = len_q;
          default:  out_byte_d = 8'h00;
        endcase
        seq_inc        = (hdr_idx_q == HDR_SEQ);
        crc_cmd.update = 1'b1;
        crc_cmd.data   = out_byte_d;
        hdr_idx_next   = hdr_idx_q + 3'd1;
        if (hdr_idx_q == HDR_LAST) begin
          phase_next = (len_q == 8'd0) ? PH_CRC_LO : PH_DATA;
        end
      end
      PH_DATA: begin
        out_byte_d     = data_q;
        crc_cmd.update = 1'b1;
        crc_cmd.data   = data_q;
        seen_d         = seen_inc[LEN_W-1:0];
        if (trailer) begin
          phase_next = PH_CRC_LO;
        end else begin
          in_frame_d = 1'b1;
          last       = 1'b1;
        end
      end
      PH_CRC_LO: begin
        out_byte_d = crc[7:0];
        phase_next = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        out_byte_d = crc[15:8];
        out_end_d  = 1'b1;
        in_frame_d = 1'b0;
        last       = 1'b1;
      end
      default: begin
        last = 1'b1;
      end
    endcase
    if (!fire) begin
      crc_cmd.init   = 1'b0;
      crc_cmd.update = 1'b0;
      seq_inc        = 1'b0;
      latched_len_d  = latched_len_q;
      seen_d         = seen_q;
      in_frame_d     = in_frame_q;
    end
  end

  // input handshake and holding register control
  assign s_axis_tready = !item_valid_q || (fire && last);
  assign load          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_valid_d = item_valid_q;
    phase_d      = phase_q;
    hdr_idx_d    = hdr_idx_q;
    if (load) begin
      item_valid_d = 1'b1;
      phase_d      = in_frame_d ? PH_DATA : PH_START;
      hdr_idx_d    = '0;
    end else if (fire) begin
      item_valid_d = !last;
      phase_d      = phase_next;
      hdr_idx_d    = hdr_idx_next;
    end
  end

  // output register control
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q  <= 1'b0;
      phase_q       <= PH_START;
      hdr_idx_q     <= '0;
      in_frame_q    <= 1'b0;
      latched_len_q <= '0;
      seen_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      item_valid_q  <= item_valid_d;
      phase_q       <= phase_d;
      hdr_idx_q     <= hdr_idx_d;
      in_frame_q    <= in_frame_d;
      latched_len_q <= latched_len_d;
      seen_q        <= seen_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // per-type sequence counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TYPES; i++) begin
        seq_q[i] <= 8'h00;
      end
    end else if (seq_inc) begin
      seq_q[type_sel] <= seq_q[type_sel] + 8'd1;
    end
  end

  // held item payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      type_q <= s_axis_tuser;
      len_q  <= s_axis_tdata[7:0];
      data_q <= s_axis_tdata[15:8];
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_q <= out_byte_d;
      out_end_q  <= out_end_d;
      out_rej_q  <= out_rej_d;
    end
  end

  // running crc
  rfe_crc16 u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (crc_cmd),
    .crc_o  (crc)
  );

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_byte_q;
  assign m_axis_tlast    = out_end_q;
  assign m_axis_tuser[0] = out_rej_q;

endmodule

`default_nettype wire
